>>> rtl/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared widths, default parameters, codes and controller/datapath structs
// for the heater PWM duty damper.
// ----------------------------------------------------------------------------
package hpd_pkg;

	localparam int DATA_W = 16;
	localparam int CNT_W  = 16;
	// Marks fit in 17 bits: low mark is all ones or at most 65535, high mark
	// is at most 65536.
	localparam int MARK_W = DATA_W + 1;

	localparam int PROD_W = 2 * DATA_W;
	localparam int NUM_W  = PROD_W + DATA_W;

	localparam int DEF_PWM_PERIOD   = 1024;
	localparam int DEF_COOLDOWN     = 20;
	localparam int DEF_ADC_DELAY    = 16;
	localparam int DEF_ADC_WORKTIME = 16;

	localparam int SETTLE_ITEMS = 3;
	localparam int STEP_OFFSET  = 2;

	localparam logic [MARK_W-1:0] MARK_LOW_RESET  = '1;
	localparam logic [MARK_W-1:0] MARK_HIGH_RESET = '0;

	typedef enum logic [1:0] {
		NUDGE_NONE  = 2'd0,
		NUDGE_RAISE = 2'd1,
		NUDGE_LOWER = 2'd2
	} nudge_t;

	typedef struct packed {
		logic load;
		logic start;
		logic finish;
	} hpd_cmd_t;

	typedef struct packed {
		logic busy;
	} hpd_status_t;

endpackage

>>> rtl/hpd_if.sv
// ----------------------------------------------------------------------------
// hpd_if
// Valid/ready stream interfaces for the request and the response channel.
// ----------------------------------------------------------------------------
interface hpd_req_if import hpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] power;
	logic [DATA_W-1:0] voltage_q8;

	modport source (output valid, output power, output voltage_q8, input ready);
	modport sink   (input valid, input power, input voltage_q8, output ready);
endinterface

interface hpd_rsp_if import hpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] compare_value;
	logic [1:0]        nudge;

	modport source (output valid, output compare_value, output nudge, input ready);
	modport sink   (input valid, input compare_value, input nudge, output ready);
endinterface

>>> rtl/hpd_div.sv
// ----------------------------------------------------------------------------
// hpd_div
// Restoring bit-serial divider, one quotient bit per cycle; keeps the low
// QUO_W bits of the quotient.
// ----------------------------------------------------------------------------
module hpd_div import hpd_pkg::*; #(
	parameter int NUM_W_P = 48,
	parameter int DEN_W_P = 32,
	parameter int QUO_W_P = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W_P-1:0] num,
	input  logic [DEN_W_P-1:0] den,
	output logic               busy,
	output logic [QUO_W_P-1:0] quo
);

	localparam int STEP_W = $clog2(NUM_W_P + 1);

	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic [NUM_W_P-1:0] num_q;
	logic [DEN_W_P-1:0] den_q;
	logic [DEN_W_P-1:0] rem_q;
	logic [QUO_W_P-1:0] quo_q;

	logic [DEN_W_P:0]   trial;
	logic [DEN_W_P:0]   diff;
	logic               qbit;

	always_comb begin
		trial = {rem_q, num_q[NUM_W_P-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(NUM_W_P);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W_P-2:0], 1'b0};
			rem_q <= qbit ? diff[DEN_W_P-1:0] : trial[DEN_W_P-1:0];
			quo_q <= {quo_q[QUO_W_P-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

>>> rtl/hpd_datapath.sv
// ----------------------------------------------------------------------------
// hpd_datapath
// Products, the two dividers, damper state and the output register.
// ----------------------------------------------------------------------------
module hpd_datapath import hpd_pkg::*; #(
	parameter int PWM_PERIOD   = DEF_PWM_PERIOD,
	parameter int COOLDOWN     = DEF_COOLDOWN,
	parameter int ADC_DELAY    = DEF_ADC_DELAY,
	parameter int ADC_WORKTIME = DEF_ADC_WORKTIME
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hpd_cmd_t          cmd,
	input  logic [DATA_W-1:0] power,
	input  logic [DATA_W-1:0] voltage_q8,
	output hpd_status_t       status,
	output logic [DATA_W-1:0] compare_value,
	output logic [1:0]        nudge
);

	localparam logic [DATA_W-1:0] PERIOD_V = DATA_W'(PWM_PERIOD);
	localparam logic [DATA_W-1:0] GUARD_V  = DATA_W'(ADC_DELAY + ADC_WORKTIME);
	localparam logic [CNT_W-1:0]  COOL_V   = CNT_W'(COOLDOWN);

	logic [PROD_W-1:0] num_prod_q;
	logic [PROD_W-1:0] den_q;
	logic              zero_q;

	logic [CNT_W-1:0]  call_counter_q;
	logic [MARK_W-1:0] low_mark_q;
	logic [MARK_W-1:0] high_mark_q;

	logic [DATA_W-1:0] compare_q;
	nudge_t            nudge_q;

	logic              main_busy;
	logic              step_busy;
	logic [DATA_W-1:0] main_quo;
	logic [DATA_W-1:0] step_quo;

	logic              settled;
	logic              cool;
	logic              expire;
	logic [CNT_W-1:0]  c1;
	logic [CNT_W-1:0]  c2;
	logic [CNT_W-1:0]  divisor;

	logic [DATA_W-1:0] raw;
	logic [MARK_W-1:0] raw_ext;
	logic [MARK_W-1:0] lo_eff;
	logic [MARK_W-1:0] hi_eff;
	logic              do_raise;
	logic              do_lower;
	logic [MARK_W-1:0] sum;
	logic [DATA_W-1:0] raised;
	logic [DATA_W-1:0] lowered;
	logic [DATA_W-1:0] nudged;
	logic [DATA_W-1:0] clamped;
	logic [DATA_W-1:0] floored;

	// Capture products at transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_prod_q <= PROD_W'(power) * PROD_W'(PERIOD_V);
			den_q      <= PROD_W'(voltage_q8) * PROD_W'(voltage_q8);
			zero_q     <= (voltage_q8 == '0);
		end
	end

	// Counter advance, known before the item ends
	always_comb begin
		settled = (call_counter_q >= CNT_W'(SETTLE_ITEMS));
		c1      = call_counter_q + CNT_W'(1);
		cool    = (c1 <= COOL_V);
		expire  = settled && !cool;
		c2      = (settled && cool) ? c1 + CNT_W'(1) : c1;
		divisor = (c2 > CNT_W'(STEP_OFFSET)) ? c2 - CNT_W'(STEP_OFFSET) : CNT_W'(1);
	end

	hpd_div #(
		.NUM_W_P(NUM_W),
		.DEN_W_P(PROD_W),
		.QUO_W_P(DATA_W)
	) u_main_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.num   ({num_prod_q, {DATA_W{1'b0}}}),
		.den   (den_q),
		.busy  (main_busy),
		.quo   (main_quo)
	);

	hpd_div #(
		.NUM_W_P(DATA_W),
		.DEN_W_P(CNT_W),
		.QUO_W_P(DATA_W)
	) u_step_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.num   (PERIOD_V),
		.den   (divisor),
		.busy  (step_busy),
		.quo   (step_quo)
	);

	assign status.busy = main_busy | step_busy;

	// Damper decision, nudge with saturation, clamp then floor
	always_comb begin
		raw      = zero_q ? '1 : main_quo;
		raw_ext  = {1'b0, raw};
		lo_eff   = expire ? MARK_LOW_RESET : low_mark_q;
		hi_eff   = expire ? MARK_HIGH_RESET : high_mark_q;
		do_raise = settled && (raw_ext < lo_eff);
		do_lower = settled && !do_raise && (raw_ext > hi_eff);
		sum      = raw_ext + {1'b0, step_quo};
		raised   = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
		lowered  = (raw > step_quo) ? raw - step_quo : '0;
		if (do_raise) begin
			nudged = raised;
		end else if (do_lower) begin
			nudged = lowered;
		end else begin
			nudged = raw;
		end
		clamped = (nudged > PERIOD_V) ? PERIOD_V : nudged;
		floored = (clamped < GUARD_V) ? GUARD_V : clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			call_counter_q <= '0;
			low_mark_q     <= MARK_LOW_RESET;
			high_mark_q    <= MARK_HIGH_RESET;
		end else if (cmd.finish) begin
			if (do_raise) begin
				low_mark_q     <= raw_ext;
				high_mark_q    <= raw_ext + MARK_W'(1);
				call_counter_q <= '0;
			end else if (do_lower) begin
				high_mark_q    <= raw_ext;
				low_mark_q     <= raw_ext - MARK_W'(1);
				call_counter_q <= '0;
			end else begin
				low_mark_q     <= lo_eff;
				high_mark_q    <= hi_eff;
				call_counter_q <= c2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			compare_q <= floored;
			if (do_raise) begin
				nudge_q <= NUDGE_RAISE;
			end else if (do_lower) begin
				nudge_q <= NUDGE_LOWER;
			end else begin
				nudge_q <= NUDGE_NONE;
			end
		end
	end

	assign compare_value = compare_q;
	assign nudge         = 2'(nudge_q);

endmodule

>>> rtl/hpd_ctrl.sv
// ----------------------------------------------------------------------------
// hpd_ctrl
// Sequencer for one item at a time plus the output valid flag.
// ----------------------------------------------------------------------------
module hpd_ctrl import hpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	input  hpd_status_t status,
	output hpd_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && req_valid;
		cmd.start  = (state_q == ST_START);
		cmd.finish = (state_q == ST_FINISH) && (!out_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (!status.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

>>> rtl/heater_pwm_duty_damper.sv
// ----------------------------------------------------------------------------
// heater_pwm_duty_damper
// One item is in flight at a time: a new request is taken only after the
// 48-step bit-serial quotient of power*period*65536 over voltage squared
// is done and the result has gone to the output register.
// A finished response waits in the output register while the next request
// is taken. Reset clears the call counter to zero and the marks to their
// empty band at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module heater_pwm_duty_damper import hpd_pkg::*; #(
	parameter int PWM_PERIOD   = DEF_PWM_PERIOD,
	parameter int COOLDOWN     = DEF_COOLDOWN,
	parameter int ADC_DELAY    = DEF_ADC_DELAY,
	parameter int ADC_WORKTIME = DEF_ADC_WORKTIME
) (
	input  logic      clk,
	input  logic      arst_n,
	hpd_req_if.sink   req,
	hpd_rsp_if.source rsp
);

	// Command and status between sequencer and datapath
	hpd_cmd_t    cmd;
	hpd_status_t status;

	// Sequencer: accept in idle, start both dividers, wait, then hand the
	// result to the output register once it is free or being drained.
	hpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: products on transfer, raw count and nudge step in two
	// dividers running side by side, damper update and output clamp on finish.
	hpd_datapath #(
		.PWM_PERIOD  (PWM_PERIOD),
		.COOLDOWN    (COOLDOWN),
		.ADC_DELAY   (ADC_DELAY),
		.ADC_WORKTIME(ADC_WORKTIME)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.power        (req.power),
		.voltage_q8   (req.voltage_q8),
		.status       (status),
		.compare_value(rsp.compare_value),
		.nudge        (rsp.nudge)
	);

endmodule

>>> test/heater_pwm_duty_damper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_pwm_duty_damper_tb
// Self-checking bench for the heater PWM duty damper. A scoreboard class
// predicts the compare count and damper action of every request transfer
// and matches them in order against the response transfers. Stimulus is a
// directed opening, then steady runs of equal requests mixed with random
// noise, under random idling on both sides, one long response hold-off,
// one drain pause and a final stretch without idling.
// ----------------------------------------------------------------------------
module heater_pwm_duty_damper_tb;
	import hpd_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 450;
	localparam int CALM_ITEMS   = 60;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AFTER   = 40;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT_CYCLES = 500000;

	typedef struct {
		logic [DATA_W-1:0] compare_value;
		nudge_t            nudge;
	} duty_result_t;

	// Scoreboard: own copy of the damper state, queue of predicted duties.
	class duty_tracker;
		duty_result_t      pending_duties[$];
		logic [CNT_W-1:0]  calls;
		logic [31:0]       low_mark;
		logic [31:0]       high_mark;
		int                mismatches;
		int                raised;
		int                lowered;
		int                unchanged;

		function new();
			calls      = '0;
			low_mark   = '1;
			high_mark  = '0;
			mismatches = 0;
			raised     = 0;
			lowered    = 0;
			unchanged  = 0;
		endfunction

		// Nudge size: period over (counter - offset), divisor never below one.
		function logic [31:0] step_size();
			logic [31:0] divisor;
			divisor = (32'(calls) > STEP_OFFSET) ? 32'(calls) - STEP_OFFSET : 32'd1;
			return 32'(DEF_PWM_PERIOD) / divisor;
		endfunction

		function void note_request(logic [DATA_W-1:0] p, logic [DATA_W-1:0] v);
			logic [63:0]      num;
			logic [63:0]      den;
			logic [63:0]      quo;
			logic [31:0]      cnt;
			logic [31:0]      step;
			logic [CNT_W-1:0] prior;
			duty_result_t     r;
			if (v == '0) begin
				cnt = 32'hFFFF;
			end else begin
				num = (64'(p) * 64'(DEF_PWM_PERIOD)) << 16;
				den = 64'(v) * 64'(v);
				quo = num / den;
				cnt = {16'd0, quo[15:0]};
			end
			r.nudge = NUDGE_NONE;
			prior   = calls;
			calls   = calls + 1'b1;
			if (prior >= SETTLE_ITEMS) begin
				if (32'(calls) <= DEF_COOLDOWN) begin
					calls = calls + 1'b1;
				end else begin
					low_mark  = '1;
					high_mark = '0;
				end
				if (cnt < low_mark) begin
					low_mark  = cnt;
					high_mark = cnt + 1;
					cnt       = cnt + step_size();
					if (cnt > 32'hFFFF) begin
						cnt = 32'hFFFF;
					end
					calls   = '0;
					r.nudge = NUDGE_RAISE;
				end else if (high_mark < cnt) begin
					high_mark = cnt;
					low_mark  = cnt - 1;
					step      = step_size();
					cnt       = (cnt > step) ? cnt - step : 32'd0;
					calls     = '0;
					r.nudge   = NUDGE_LOWER;
				end
			end
			// Clamp to the period first, then the guard floor wins.
			if (cnt > 32'(DEF_PWM_PERIOD)) begin
				cnt = 32'(DEF_PWM_PERIOD);
			end
			if (cnt < 32'(DEF_ADC_DELAY + DEF_ADC_WORKTIME)) begin
				cnt = 32'(DEF_ADC_DELAY + DEF_ADC_WORKTIME);
			end
			r.compare_value = cnt[DATA_W-1:0];
			pending_duties.push_back(r);
		endfunction

		function void check_response(logic [DATA_W-1:0] cv, logic [1:0] nd);
			duty_result_t want;
			if (pending_duties.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR response cv=%0d nudge=%0d with nothing pending", cv, nd);
				end
				return;
			end
			want = pending_duties.pop_front();
			case (want.nudge)
				NUDGE_RAISE: raised++;
				NUDGE_LOWER: lowered++;
				default:     unchanged++;
			endcase
			if (cv !== want.compare_value || nd !== want.nudge) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR compare_value exp %0d got %0d, nudge exp %0d got %0d",
						want.compare_value, cv, want.nudge, nd);
				end
			end
		endfunction

		function int pending();
			return pending_duties.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	hpd_req_if req ();
	hpd_rsp_if rsp ();

	heater_pwm_duty_damper #(
		.PWM_PERIOD   (DEF_PWM_PERIOD),
		.COOLDOWN     (DEF_COOLDOWN),
		.ADC_DELAY    (DEF_ADC_DELAY),
		.ADC_WORKTIME (DEF_ADC_WORKTIME)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	duty_tracker tracker = new();

	// Shared flags change only by nonblocking assignment at the clock edge.
	logic hold_out = 1'b0;
	logic calm     = 1'b0;
	int   resp_count = 0;
	int   sent_count = 0;
	int   zero_volt_count = 0;
	int   stall_left = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Offer one request, hold it until the transfer, then maybe idle.
	task automatic send_request(logic [DATA_W-1:0] p, logic [DATA_W-1:0] v);
		req.valid      <= 1'b1;
		req.power      <= p;
		req.voltage_q8 <= v;
		do begin
			@(posedge clk);
		end while (!req.ready);
		tracker.note_request(p, v);
		sent_count++;
		if (v == '0) begin
			zero_volt_count++;
		end
		if (!calm && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Hold until every predicted duty has come back; poll off the active edge.
	task automatic wait_drained();
		while (tracker.pending() != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Response side: check each transfer, then pick ready for the next edge.
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				tracker.check_response(rsp.compare_value, rsp.nudge);
				resp_count <= resp_count + 1;
			end
			if (!arst_n || hold_out) begin
				rsp.ready <= 1'b0;
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				// Start a stall burst; its remaining length is drawn into stall_left.
				rsp.ready  <= 1'b0;
				stall_left = $urandom_range(0, 7);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Long hold-off on the response side while requests keep coming, so the
	// output register fills and the block stalls its input.
	initial begin
		while (resp_count < HOLD_AFTER) begin
			@(negedge clk);
		end
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_out <= 1'b0;
	end

	// Watchdog.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("TIMEOUT after %0d cycles, %0d responses still pending",
			LIMIT_CYCLES, tracker.pending());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int               rand_done;
		int               kind;
		int               run_len;
		int               i;
		logic [DATA_W-1:0] p;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] pj;

		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.power      <= '0;
		req.voltage_q8 <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. The first three pass straight through the damper:
		// zero voltage at both power extremes, then a quotient that wraps to 0.
		send_request(16'h0000, 16'h0000);
		send_request(16'hFFFF, 16'h0000);
		send_request(16'hFFFF, 16'h0001);
		// Zero count against the empty band: raise.
		send_request(16'h0000, 16'hFFFF);
		// Settle items; the quotient here keeps only its low 16 bits.
		repeat (3) send_request(16'd100, 16'h0100);
		// Count 100 above the band, step 341: lower saturates at zero.
		send_request(16'd6400, 16'hFFFF);
		// Sit on the high mark until the cooldown forgets the band.
		repeat (12) send_request(16'd6400, 16'hFFFF);
		// Full count against the forgotten band: raise saturates at the top.
		send_request(16'hFFFF, 16'h0000);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'h8000, 16'h8000);

		// Drain pause: idle the request side until all responses are in.
		req.valid <= 1'b0;
		wait_drained();

		rand_done = 0;
		while (rand_done < RANDOM_ITEMS) begin
			if (rand_done >= RANDOM_ITEMS - CALM_ITEMS) begin
				calm <= 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				// Steady run around a realistic operating point, light jitter.
				v       = 16'($urandom_range(1024, 16383));
				p       = 16'($urandom_range(0, 1500));
				run_len = $urandom_range(1, 24);
				for (i = 0; i < run_len && rand_done < RANDOM_ITEMS; i++) begin
					pj = p;
					if ($urandom_range(0, 7) == 0) begin
						pj = p + 16'($urandom_range(0, 3));
					end
					send_request(pj, v);
					rand_done++;
				end
			end else if (kind < 8) begin
				send_request(16'($urandom), 16'($urandom));
				rand_done++;
			end else if (kind == 8) begin
				send_request(16'($urandom), 16'h0000);
				rand_done++;
			end else begin
				// Big power over a tiny voltage: wrapped quotient.
				send_request(16'($urandom_range(16'h8000, 16'hFFFF)),
					16'($urandom_range(1, 255)));
				rand_done++;
			end
		end

		req.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d at zero voltage): %0d raised, %0d lowered, %0d left",
			sent_count, zero_volt_count, tracker.raised, tracker.lowered, tracker.unchanged);
		$display("Run held responses for %0d cycles, drained once mid-run, ended without idling",
			LONG_HOLD);
		if (tracker.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d bad responses in total", tracker.mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
